// ===== hw/rtl/length_prefixed_byte_stack_unit_macros.svh =====
// Assertion macros for the length-prefixed byte stack unit.
// Expects clk and rst in the scope where a macro is used.
`ifndef LENGTH_PREFIXED_BYTE_STACK_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_BYTE_STACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPBS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lpbs_pkg.sv =====
// Shared types and constants for the length-prefixed byte stack unit.
// No dependencies.
`timescale 1ns / 1ps

package lpbs_pkg;

  localparam int MAX_OUT     = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_POP   = 3'd1;
  localparam logic [2:0] MODE_PEEK  = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_CHECK = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_CLEAR,
    OP_CHECK,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic [5:0] length;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR_WRITE,
    ST_HDR_READ,
    ST_BYTES
  } state_t;

endpackage

// ===== hw/rtl/lpbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lpbs_front.sv =====
// Front end: takes requests, decodes the mode and queues commands.
// Depends on lpbs_pkg.
`timescale 1ns / 1ps

module lpbs_front import lpbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] mode,
  input  logic [7:0] data_byte,
  input  logic [5:0] length,
  output logic       busy,
  output cmd_t       head,
  output logic       head_valid,
  input  logic       deq
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          q [QUEUE_DEPTH];
  cmd_t          cmd_in;
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          enq;

  always_comb begin
    cmd_in.data_byte = data_byte;
    cmd_in.length    = length;
    case (mode)
      MODE_PUSH:  cmd_in.op = OP_PUSH;
      MODE_POP:   cmd_in.op = OP_POP;
      MODE_PEEK:  cmd_in.op = OP_PEEK;
      MODE_CLEAR: cmd_in.op = OP_CLEAR;
      MODE_CHECK: cmd_in.op = OP_CHECK;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign busy       = (count == CW'(QUEUE_DEPTH));
  assign enq        = start && !busy;
  assign head       = q[rptr];
  assign head_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (deq) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      case ({enq, deq})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wptr] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/lpbs_back.sv =====
// Back end: executes queued commands against the byte store and drives results.
// Depends on lpbs_pkg, lpbs_ram and the unit's assertion macros.
`timescale 1ns / 1ps

`include "length_prefixed_byte_stack_unit_macros.svh"

module lpbs_back import lpbs_pkg::*; #(
  parameter int STORE_BYTES  = 1024,
  parameter int MAX_RECORD   = 32,
  parameter int HEADER_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       head_valid,
  output logic       deq,
  output logic       strobe,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       is_empty,
  output logic       last
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int TW = $clog2(STORE_BYTES + 1);
  localparam int SW = TW + 2;

  state_t        state, state_next;
  logic [TW-1:0] top, top_next;
  logic [5:0]    progress, progress_next;
  logic          rejected, rejected_next;
  logic [5:0]    plen, plen_next;
  logic [AW-1:0] wptr, wptr_next;
  logic          is_pop, is_pop_next;
  logic [5:0]    req_len, req_len_next;
  logic [5:0]    nbytes, nbytes_next;
  logic [5:0]    cnt, cnt_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;

  logic          strobe_next;
  logic [7:0]    out_byte_next;
  logic          byte_valid_next;
  logic [1:0]    status_next;
  logic          is_empty_next;
  logic          last_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  logic          first;
  logic          fits_len;
  logic [5:0]    cur_len;
  logic          cur_rej;
  logic [AW-1:0] push_addr;
  logic [6:0]    step;
  logic [TW-1:0] new_top;
  logic [7:0]    n_min;
  logic [5:0]    n_cap;
  logic [SW-1:0] pop_sum;
  logic [TW-1:0] pop_top;
  logic [6:0]    cnt_step;

  lpbs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign first     = (progress == '0);
  assign fits_len  = ({1'b0, head.length} <= 7'(MAX_RECORD)) &&
                     (top >= TW'(head.length) + TW'(HEADER_BYTES));
  assign cur_len   = first ? head.length : plen;
  assign cur_rej   = first ? !fits_len : rejected;
  assign push_addr = first ? AW'(top - TW'(head.length)) : wptr;
  assign step      = {1'b0, progress} + 7'd1;
  assign new_top   = top - TW'(cur_len) - TW'(HEADER_BYTES);

  assign n_min   = (rdata < {2'b00, req_len}) ? rdata : {2'b00, req_len};
  assign n_cap   = (n_min > 8'(MAX_OUT)) ? 6'(MAX_OUT) : n_min[5:0];
  assign pop_sum = SW'(top) + SW'(HEADER_BYTES) + SW'(rdata);
  assign pop_top = (pop_sum > SW'(STORE_BYTES)) ? TW'(STORE_BYTES) : pop_sum[TW-1:0];
  assign cnt_step = {1'b0, cnt} + 7'd1;

  always_comb begin
    state_next      = state;
    top_next        = top;
    progress_next   = progress;
    rejected_next   = rejected;
    plen_next       = plen;
    wptr_next       = wptr;
    is_pop_next     = is_pop;
    req_len_next    = req_len;
    nbytes_next     = nbytes;
    cnt_next        = cnt;
    rd_ptr_next     = rd_ptr;
    deq             = 1'b0;
    we              = 1'b0;
    waddr           = push_addr;
    wdata           = head.data_byte;
    raddr           = top[AW-1:0];
    strobe_next     = 1'b0;
    out_byte_next   = '0;
    byte_valid_next = 1'b0;
    status_next     = STATUS_OK;
    last_next       = 1'b1;

    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          deq         = 1'b1;
          strobe_next = 1'b1;
          if (head.op != OP_PUSH) begin
            progress_next = '0;
            rejected_next = 1'b0;
          end
          case (head.op)
            OP_PUSH: begin
              if (first && head.length == '0) begin
                // header-only record
                status_next = fits_len ? STATUS_OK : STATUS_FULL;
                if (fits_len) begin
                  we       = 1'b1;
                  waddr    = AW'(top - TW'(HEADER_BYTES));
                  wdata    = '0;
                  top_next = top - TW'(HEADER_BYTES);
                end
                progress_next = '0;
                rejected_next = 1'b0;
              end else begin
                status_next = cur_rej ? STATUS_FULL : STATUS_OK;
                plen_next   = cur_len;
                we          = !cur_rej;
                wptr_next   = push_addr + AW'(1);
                if (step >= {1'b0, cur_len}) begin
                  progress_next = '0;
                  rejected_next = 1'b0;
                  if (!cur_rej) begin
                    top_next   = new_top;
                    state_next = ST_HDR_WRITE;
                  end
                end else begin
                  progress_next = step[5:0];
                  rejected_next = cur_rej;
                end
              end
            end
            OP_POP, OP_PEEK: begin
              if (top >= TW'(STORE_BYTES)) begin
                status_next = STATUS_EMPTY;
              end else begin
                strobe_next  = 1'b0;
                is_pop_next  = (head.op == OP_POP);
                req_len_next = head.length;
                state_next   = ST_HDR_READ;
              end
            end
            OP_CLEAR: begin
              top_next = TW'(STORE_BYTES);
            end
            OP_CHECK: begin
              status_next = fits_len ? STATUS_OK : STATUS_FULL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_HDR_WRITE: begin
        // write the length byte of the record just completed
        we         = 1'b1;
        waddr      = top[AW-1:0];
        wdata      = {2'b00, plen};
        state_next = ST_IDLE;
      end
      ST_HDR_READ: begin
        if (is_pop) begin
          top_next = pop_top;
        end
        nbytes_next = n_cap;
        cnt_next    = '0;
        raddr       = AW'(top + TW'(HEADER_BYTES));
        rd_ptr_next = AW'(top + TW'(HEADER_BYTES)) + AW'(1);
        if (n_cap == '0) begin
          strobe_next = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          state_next = ST_BYTES;
        end
      end
      ST_BYTES: begin
        strobe_next     = 1'b1;
        out_byte_next   = rdata;
        byte_valid_next = 1'b1;
        last_next       = (cnt_step == {1'b0, nbytes});
        raddr           = rd_ptr;
        rd_ptr_next     = rd_ptr + AW'(1);
        cnt_next        = cnt_step[5:0];
        if (last_next) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    is_empty_next = (top_next >= TW'(STORE_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      top      <= TW'(STORE_BYTES);
      progress <= '0;
      rejected <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      top      <= top_next;
      progress <= progress_next;
      rejected <= rejected_next;
      strobe   <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    plen       <= plen_next;
    wptr       <= wptr_next;
    is_pop     <= is_pop_next;
    req_len    <= req_len_next;
    nbytes     <= nbytes_next;
    cnt        <= cnt_next;
    rd_ptr     <= rd_ptr_next;
    out_byte   <= out_byte_next;
    byte_valid <= byte_valid_next;
    status     <= status_next;
    is_empty   <= is_empty_next;
    last       <= last_next;
  end

  `LPBS_ASSERT_IMPLY(a_hdr_write_after_ok, state == ST_HDR_WRITE, strobe && last && status == STATUS_OK, "header write without a completed push")
  `LPBS_ASSERT_IMPLY(a_byte_count_range, state == ST_BYTES, cnt < nbytes, "byte counter past record length")
  `LPBS_ASSERT_IMPLY(a_top_in_store, 1'b1, top <= TW'(STORE_BYTES), "top pointer outside the store")
  `LPBS_ASSERT_NEXT(a_bytes_contiguous, strobe && byte_valid && !last, strobe && byte_valid, "gap inside a byte burst")

endmodule

// ===== hw/rtl/length_prefixed_byte_stack_unit.sv =====
// Top level of the length-prefixed byte stack unit.
// Depends on lpbs_pkg, lpbs_front and lpbs_back.
//
// A request is taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full. Results come on strobe, one per cycle, and
// last marks the final result of a request. Results cannot be held off: the receiver
// must take each one in the cycle it appears. The final byte of an accepted record
// is followed by a write of the length header through the store's single write port.
// Pop and peek first address the header, then wait for its registered read, then
// return one byte per cycle; on an empty stack they return an empty status without
// reading. Clear, check and unused modes give a single result. The store needs no
// clearing pass, so requests are taken as soon as reset is released.
`timescale 1ns / 1ps

module length_prefixed_byte_stack_unit import lpbs_pkg::*; #(
  parameter int STORE_BYTES  = 1024,
  parameter int MAX_RECORD   = 32,
  parameter int HEADER_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] mode,
  input  logic [7:0] data_byte,
  input  logic [5:0] length,
  output logic       busy,
  output logic       strobe,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       is_empty,
  output logic       last
);

  cmd_t head;
  logic head_valid;
  logic deq;

  lpbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .data_byte  (data_byte),
    .length     (length),
    .busy       (busy),
    .head       (head),
    .head_valid (head_valid),
    .deq        (deq)
  );

  lpbs_back #(
    .STORE_BYTES  (STORE_BYTES),
    .MAX_RECORD   (MAX_RECORD),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .deq        (deq),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .is_empty   (is_empty),
    .last       (last)
  );

endmodule
